// ===== sv/ofip_pkg.sv =====
// Shared constants for the face index parser: character codes, item kinds, parser codes.
package ofip_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_VERTS  = 16;
   localparam int DEF_INDEX_BITS = 24;

   // Fixed result field widths
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   // Result queue depth
   localparam int QUEUE_DEPTH = 4;

   // Character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Result item kinds
   localparam logic KIND_TRIPLET = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Number scanner phases
   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   // Subfield positions within a group
   localparam logic [1:0] SUB_VERT  = 2'd0;
   localparam logic [1:0] SUB_TEX   = 2'd1;
   localparam logic [1:0] SUB_NORM  = 2'd2;
   localparam logic [1:0] SUB_EXTRA = 2'd3;

endpackage

// ===== sv/obj_face_index_parser.sv =====
// Face line index parser: byte stream in, vertex/texture/normal triplets and end items out.
//
//  channel  dir  handshake                    payload
//  req      in   req_tvalid / req_tready      tdata[7:0] char_byte, tlast line_end
//  rsp      out  rsp_tvalid / rsp_tready      tdata: slot, vertex, texcoord, normal,
//                                             count, overflow; tlast item_kind
//
// One byte is taken per cycle while the result queue has room. A byte is held in the input
// register, is parsed there and its results (none, one or two) land in a four-entry result
// queue whose head drives rsp; a byte passes the input register, then the queue, to reach rsp.
// The parser fires only when the queue has room for two items, so a stalled rsp side
// backs up into the input register and then drops req_tready.
// An end-of-line byte that also closes a group gives two items, drained one per cycle while rsp_tready is high.
// Synchronous reset clears the input register's valid flag, the queue count and the line state.
module obj_face_index_parser #(
   parameter int MAX_VERTS  = ofip_pkg::DEF_MAX_VERTS,
   parameter int INDEX_BITS = ofip_pkg::DEF_INDEX_BITS,
   localparam int RSP_USED_W = ofip_pkg::SLOT_W + ofip_pkg::COUNT_W + 1 + 3 * INDEX_BITS,
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] char_byte
   input  logic                  req_tlast,  // line_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // low to high: slot_index(4), vertex_index, texcoord_index, normal_index
   // (INDEX_BITS each), face_vertex_count(5), overflow_flag(1), zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast   // item_kind: 1 = end of line
);
   import ofip_pkg::*;

   localparam int W    = INDEX_BITS;
   localparam int GC_W = $clog2(MAX_VERTS + 1);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QI_W = $clog2(QUEUE_DEPTH);
   localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

   typedef struct packed {
      logic [1:0]      sub;
      logic            open;
      logic            nonempty;
      logic [1:0]      phase;
      logic            neg;
      logic [W-1:0]    acc;     // magnitude, clamps at 2^(W-1)
      logic [W-1:0]    hv;
      logic [W-1:0]    ht;
      logic [W-1:0]    hn;
      logic [GC_W-1:0] gc;
      logic            dropped;
   } parse_state_type;

   typedef struct packed {
      logic               kind;
      logic               ovf;
      logic [COUNT_W-1:0] cnt;
      logic [W-1:0]       hn;
      logic [W-1:0]       ht;
      logic [W-1:0]       hv;
      logic [SLOT_W-1:0]  slot;
   } result_type;

   // ---------------- parser helpers ----------------
   function automatic parse_state_type number_clear(parse_state_type s);
      s.phase    = PH_SKIP;
      s.neg      = 1'b0;
      s.acc      = '0;
      s.nonempty = 1'b0;
      return s;
   endfunction

   function automatic parse_state_type line_clear();
      parse_state_type s;
      s      = '0;
      s      = number_clear(s);
      s.sub  = SUB_VERT;
      s.open = 1'b0;
      s.hv   = '0;
      s.ht   = '1;
      s.hn   = '1;
      s.gc   = '0;
      s.dropped = 1'b0;
      return s;
   endfunction

   function automatic logic [W-1:0] number_value(parse_state_type s);
      logic [W-1:0] v;
      if (s.neg) begin
         v = ~s.acc + 1'b1;
      end else begin
         v = (s.acc > LIM) ? LIM : s.acc;
      end
      return v;
   endfunction

   function automatic parse_state_type number_feed(parse_state_type s, logic [7:0] c);
      logic         digit;
      logic [W+3:0] prod;
      logic [W+3:0] top;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      top   = (W+4)'(LIM) + 1'b1;
      prod  = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (W+4)'(c[3:0]);
      s.nonempty = 1'b1;
      if (s.phase == PH_DONE) begin
         s.phase = PH_DONE;
      end else if (s.phase == PH_SKIP && c >= CH_TAB && c <= CH_CR) begin
         s.phase = PH_SKIP;   // leading whitespace
      end else if (s.phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
         s.neg   = (c == CH_MINUS);
         s.phase = PH_SIGN;
      end else if (!digit) begin
         s.phase = PH_DONE;
      end else begin
         s.phase = PH_DIGITS;
         s.acc   = (prod > top) ? top[W-1:0] : prod[W-1:0];
      end
      return s;
   endfunction

   function automatic parse_state_type subfield_close(parse_state_type s);
      logic [W-1:0] v;
      v = number_value(s);
      if (s.sub == SUB_VERT) begin
         s.hv = v;
      end else if (s.sub == SUB_TEX) begin
         if (s.nonempty) begin
            s.ht = v;
         end
      end else if (s.sub == SUB_NORM) begin
         s.hn = v;
      end
      if (s.sub != SUB_EXTRA) begin
         s.sub = s.sub + 2'd1;
      end
      s = number_clear(s);
      return s;
   endfunction

   // ---------------- input register ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff,  s1_byte_in;
   logic       s1_last_ff,  s1_last_in;
   logic       fire;
   logic       pop;

   logic [QC_W-1:0] cnt_ff, cnt_in;
   result_type      q_ff [QUEUE_DEPTH];
   result_type      q_in [QUEUE_DEPTH];

   parse_state_type ps_ff, ps_in;
   result_type      trip;
   result_type      fin;
   logic            trip_ok;

   // parse only with room for two results
   assign fire       = s1_valid_ff && (cnt_ff <= QC_W'(QUEUE_DEPTH - 2));
   assign req_tready = !s1_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_last_in  = req_tlast;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- byte parser ----------------
   always_comb begin
      parse_state_type s;
      logic            close_now;
      s       = ps_ff;
      trip    = '0;
      fin     = '0;
      trip_ok = 1'b0;

      if (s1_byte_ff != CH_SPACE) begin
         if (!s.open) begin
            s.open = 1'b1;
            s.sub  = SUB_VERT;
            s      = number_clear(s);
            s.hv   = '0;
            s.ht   = '1;
            s.hn   = '1;
         end
         if (s1_byte_ff == CH_SLASH) begin
            s = subfield_close(s);
         end else begin
            s = number_feed(s, s1_byte_ff);
         end
      end

      // a space or the final byte closes an open group
      close_now = s.open && ((s1_byte_ff == CH_SPACE) || s1_last_ff);
      if (close_now) begin
         s = subfield_close(s);
         if (s.gc < GC_W'(MAX_VERTS)) begin
            trip_ok   = 1'b1;
            trip.kind = KIND_TRIPLET;
            trip.slot = SLOT_W'(s.gc);
            trip.hv   = s.hv;
            trip.ht   = s.ht;
            trip.hn   = s.hn;
            s.gc      = s.gc + 1'b1;
         end else begin
            s.dropped = 1'b1;
         end
         s.open = 1'b0;
      end

      if (s1_last_ff) begin
         fin.kind = KIND_END;
         fin.cnt  = COUNT_W'(s.gc);
         fin.ovf  = s.dropped;
         s        = line_clear();
      end

      ps_in = fire ? s : ps_ff;
   end

   // ---------------- result queue, head drives rsp ----------------
   always_comb begin
      logic [QC_W-1:0] c;
      q_in = q_ff;
      c    = cnt_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         c = c - 1'b1;
      end
      if (fire && trip_ok) begin
         q_in[c[QI_W-1:0]] = trip;
         c = c + 1'b1;
      end
      if (fire && s1_last_ff) begin
         q_in[c[QI_W-1:0]] = fin;
         c = c + 1'b1;
      end
      cnt_in = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         ps_ff       <= line_clear();
      end else begin
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
         ps_ff       <= ps_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      q_ff       <= q_in;
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tlast  = q_ff[0].kind;
   assign rsp_tdata  = RSP_DATA_W'({q_ff[0].ovf, q_ff[0].cnt, q_ff[0].hn,
                                    q_ff[0].ht, q_ff[0].hv, q_ff[0].slot});

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QC_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      ps_ff.gc <= GC_W'(MAX_VERTS))
      else $error("group count past bound");

   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> q_ff[0].slot == '0 && q_ff[0].hv == '0
                                  && q_ff[0].ht == '0 && q_ff[0].hn == '0)
      else $error("end item carries index data");

   a_line_reset: assert property (@(posedge clock) disable iff (reset)
      fire && s1_last_ff |=> ps_ff.gc == '0 && !ps_ff.open && !ps_ff.dropped)
      else $error("line state not cleared after final byte");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff))
      else $error("input register lost a pending byte");
`endif

endmodule
